/* rtl/tspp_pkg.sv */
// Shared types and constants for the TS PAT/PMT section parser.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package tspp_pkg;

    localparam int unsigned PACKET_BYTES = 188;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
    } t_in;

    typedef struct packed {
        logic        entry_kind;
        logic [15:0] program_number;
        logic [12:0] stream_pid;
        logic [7:0]  stream_type;
        logic        table_full;
    } t_out;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_HDR     = 4'd1,
        PH_AFLEN   = 4'd2,
        PH_AFSKIP  = 4'd3,
        PH_PTR     = 4'd4,
        PH_PTRSKIP = 4'd5,
        PH_TBLHDR  = 4'd6,
        PH_PINFO   = 4'd7,
        PH_ENTRY   = 4'd8,
        PH_ESSKIP  = 4'd9,
        PH_DONE    = 4'd10
    } t_phase;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_SCAN_HDR,
        ST_SCAN_PAT,
        ST_EMIT_PAT
    } t_state;

    localparam logic       KIND_PAT = 1'b0;
    localparam logic       KIND_PMT = 1'b1;
    localparam logic [1:0] FC_PAYLOAD = 2'd1;
    localparam logic [1:0] FC_BOTH    = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic step;       // an input beat is taken this edge
        logic scan;       // walk the PMT PID set
        logic set_known;  // latch header lookup result
        logic emit_pat;   // finish a looked-up PAT entry
        logic out_taken;  // result beat leaves this edge
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hdr_scan;   // this beat needs a lookup of the packet PID
        logic pat_scan;   // this beat completes a PAT entry that needs a lookup
        logic scan_done;
        logic out_busy;
    } t_sts;

endpackage
`default_nettype wire

/* rtl/ts_pat_pmt_section_parser_unit.sv */
// Top level of the TS PAT/PMT section parser: controller plus datapath.
// Depends on tspp_pkg, tspp_ctrl and tspp_dp.
`timescale 1ns / 1ps
`default_nettype none
// Takes one transport-stream byte per beat and emits one result per completed
// PAT program entry or PMT elementary stream entry. The byte that completes
// a packet's PID (when nonzero) and the byte that completes a PAT entry with a
// nonzero program and PID hold the input for a walk of the PMT PID set, one
// stored entry per cycle through its read port; a PAT entry then issues its
// result from the emit state. While a result sits in the result register under
// an output stall, the input is held as well, whether or not the next byte
// would produce a result. No clearing pass follows reset.
module ts_pat_pmt_section_parser_unit #(
    parameter int unsigned PMT_SET_DEPTH = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire tspp_pkg::t_in  i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output tspp_pkg::t_out      o_out
);
    import tspp_pkg::*;

    t_cmd   cmd;
    t_sts   sts;
    t_state state;

    tspp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_state     (state)
    );

    tspp_dp #(
        .PMT_SET_DEPTH (PMT_SET_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    a_accept_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> (state == ST_RUN))
        else $error("input beat taken outside run state");

    a_full_only_pat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.table_full && o_out.entry_kind == KIND_PMT))
        else $error("table_full on a PMT result");

    a_hdr_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state == ST_SCAN_HDR) |=> (state == ST_SCAN_HDR || state == ST_RUN))
        else $error("header lookup left to wrong state");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit_pat |=> (o_out_valid && o_out.entry_kind == KIND_PAT))
        else $error("PAT result not loaded");

endmodule
`default_nettype wire

/* rtl/tspp_ctrl.sv */
// Sequencing controller: byte acceptance, set lookups and PAT result issue.
// Depends on tspp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tspp_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_out_stall,
    input  wire tspp_pkg::t_sts  i_sts,
    output tspp_pkg::t_cmd       o_cmd,
    output logic                 o_in_stall,
    output tspp_pkg::t_state     o_state
);
    import tspp_pkg::*;

    t_state r_state, n_state;
    logic   out_free;

    assign out_free = !i_sts.out_busy || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (o_cmd.step && i_sts.hdr_scan) n_state = ST_SCAN_HDR;
                else if (o_cmd.step && i_sts.pat_scan) n_state = ST_SCAN_PAT;
            end
            ST_SCAN_HDR: begin
                if (i_sts.scan_done) n_state = ST_RUN;
            end
            ST_SCAN_PAT: begin
                if (i_sts.scan_done) n_state = ST_EMIT_PAT;
            end
            ST_EMIT_PAT: begin
                if (out_free) n_state = ST_RUN;
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_comb begin
        o_in_stall        = (r_state != ST_RUN) || !out_free;
        o_cmd.step        = i_in_valid && !o_in_stall;
        o_cmd.scan        = (r_state == ST_SCAN_HDR) || (r_state == ST_SCAN_PAT);
        o_cmd.set_known   = (r_state == ST_SCAN_HDR) && i_sts.scan_done;
        o_cmd.emit_pat    = (r_state == ST_EMIT_PAT) && out_free;
        o_cmd.out_taken   = i_sts.out_busy && !i_out_stall;
    end

    assign o_state = r_state;

endmodule
`default_nettype wire

/* rtl/tspp_dp.sv */
// Datapath: packet/section parse registers, PMT PID set memory with a
// one-entry-per-cycle lookup, and the result register. Depends on tspp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tspp_dp #(
    parameter int unsigned PMT_SET_DEPTH = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tspp_pkg::t_in  i_in,
    input  wire tspp_pkg::t_cmd i_cmd,
    output tspp_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    output tspp_pkg::t_out      o_out
);
    import tspp_pkg::*;

    localparam int unsigned AW = (PMT_SET_DEPTH > 1) ? $clog2(PMT_SET_DEPTH) : 1;
    localparam int unsigned CW = $clog2(PMT_SET_DEPTH + 1);
    localparam logic [CW-1:0] SET_MAX = CW'(PMT_SET_DEPTH);

    logic [12:0] r_set [PMT_SET_DEPTH];

    logic [7:0]  r_pos, n_pos;
    logic [12:0] r_pid, n_pid;
    logic        r_usf, n_usf;
    logic [1:0]  r_fc, n_fc;
    logic [7:0]  r_skip, n_skip;
    t_phase      r_phase, n_phase;
    logic [11:0] r_sec, n_sec;
    logic [11:0] r_es, n_es;
    logic [39:0] r_ea, n_ea;
    logic [2:0]  r_ebc, n_ebc;
    logic        r_known;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [12:0] r_key;
    logic [12:0] r_rd;
    logic        r_rd_vld;
    logic        r_hit;
    logic        r_out_valid;
    t_out        r_out;

    logic        emit_now;
    t_out        emit_data;
    logic        hdr_scan, pat_scan;
    logic [12:0] scan_key;
    t_phase      pb_phase;
    logic [7:0]  b, pos1, skip_dec, skip_inc;
    logic [11:0] sec_dec, es_dec;
    logic [39:0] ea_sh;
    logic [2:0]  ebc1, need;
    logic        is_pat, scan_done, set_ins;

    assign b        = i_in.data_byte;
    assign is_pat   = (r_pid == 13'd0);
    assign pos1     = r_pos + 8'd1;
    assign skip_dec = (r_skip != 8'd0) ? r_skip - 8'd1 : r_skip;
    assign skip_inc = r_skip + 8'd1;
    assign sec_dec  = (r_sec != 12'd0) ? r_sec - 12'd1 : r_sec;
    assign es_dec   = (r_es != 12'd0) ? r_es - 12'd1 : r_es;
    assign ea_sh    = {r_ea[31:0], b};
    assign ebc1     = r_ebc + 3'd1;
    assign need     = is_pat ? 3'd4 : 3'd5;
    assign pb_phase = (!r_usf || (!is_pat && !r_known)) ? PH_DONE : PH_PTR;

    always_comb begin
        n_pos = r_pos; n_pid = r_pid; n_usf = r_usf; n_fc = r_fc;
        n_skip = r_skip; n_phase = r_phase; n_sec = r_sec; n_es = r_es;
        n_ea = r_ea; n_ebc = r_ebc;
        emit_now = 1'b0; emit_data = '0;
        hdr_scan = 1'b0; pat_scan = 1'b0; scan_key = '0;
        if (i_in.packet_start) begin
            n_pos   = '0;
            n_phase = PH_HDR;
        end else if (r_phase != PH_IDLE) begin
            if (pos1 >= 8'(PACKET_BYTES)) begin
                n_pos   = 8'(PACKET_BYTES);
                n_phase = PH_IDLE;
            end else begin
                n_pos = pos1;
                unique case (r_phase)
                    PH_HDR: begin
                        if (pos1 == 8'd1) begin
                            n_usf = b[6];
                            n_pid = {b[4:0], 8'd0};
                        end else if (pos1 == 8'd2) begin
                            n_pid    = {r_pid[12:8], b};
                            hdr_scan = ({r_pid[12:8], b} != 13'd0);
                            scan_key = {r_pid[12:8], b};
                        end else begin
                            n_fc = b[5:4];
                            if (b[5:4] == FC_BOTH) n_phase = PH_AFLEN;
                            else if (b[5:4] == FC_PAYLOAD) n_phase = pb_phase;
                            else n_phase = PH_DONE;
                        end
                    end
                    PH_AFLEN: begin
                        n_skip  = b;
                        n_phase = (b == 8'd0) ? pb_phase : PH_AFSKIP;
                    end
                    PH_AFSKIP: begin
                        n_skip = skip_dec;
                        if (skip_dec == 8'd0) n_phase = pb_phase;
                    end
                    PH_PTR: begin
                        n_skip  = b;
                        n_phase = (b == 8'd0) ? PH_TBLHDR : PH_PTRSKIP;
                    end
                    PH_PTRSKIP: begin
                        n_skip = skip_dec;
                        if (skip_dec == 8'd0) n_phase = PH_TBLHDR;
                    end
                    PH_TBLHDR: begin
                        if (r_skip == 8'd1) begin
                            n_ea = {36'd0, b[3:0]};
                        end else if (r_skip == 8'd2) begin
                            n_sec = {r_ea[3:0], b};
                        end else if (r_skip >= 8'd3) begin
                            n_sec = sec_dec;
                            if (r_skip == 8'd10) n_ea = {36'd0, b[3:0]};
                            if (r_skip == 8'd11) n_es = {r_ea[3:0], b};
                        end
                        n_skip = skip_inc;
                        if (is_pat && skip_inc == 8'd8) begin
                            n_phase = PH_ENTRY;
                            n_ebc   = '0;
                        end else if (!is_pat && skip_inc == 8'd12) begin
                            n_phase = (n_es == 12'd0) ? PH_ENTRY : PH_PINFO;
                            n_ebc   = '0;
                        end
                    end
                    PH_PINFO, PH_ESSKIP: begin
                        if (r_sec <= 12'd4) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_sec = sec_dec;
                            n_es  = es_dec;
                            if (es_dec == 12'd0) begin
                                n_phase = PH_ENTRY;
                                n_ebc   = '0;
                            end
                        end
                    end
                    PH_ENTRY: begin
                        if (r_ebc == 3'd0 && r_sec < ({9'd0, need} + 12'd4)) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_sec = sec_dec;
                            n_ea  = ea_sh;
                            if (ebc1 < need) begin
                                n_ebc = ebc1;
                            end else begin
                                n_ebc = '0;
                                if (is_pat) begin
                                    if (ea_sh[31:16] != 16'd0 && ea_sh[12:0] != 13'd0) begin
                                        pat_scan = 1'b1;
                                        scan_key = ea_sh[12:0];
                                    end else begin
                                        emit_now = 1'b1;
                                        emit_data.entry_kind     = KIND_PAT;
                                        emit_data.program_number = ea_sh[31:16];
                                        emit_data.stream_pid     = ea_sh[12:0];
                                    end
                                end else begin
                                    emit_now = 1'b1;
                                    emit_data.entry_kind  = KIND_PMT;
                                    emit_data.stream_pid  = ea_sh[28:16];
                                    emit_data.stream_type = ea_sh[39:32];
                                    n_es = ea_sh[11:0];
                                    if (ea_sh[11:0] != 12'd0) n_phase = PH_ESSKIP;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign scan_done = (r_idx >= r_count) && !r_rd_vld;
    assign set_ins   = i_cmd.emit_pat && !r_hit && (r_count < SET_MAX);

    // set storage and lookup read port
    always_ff @(posedge i_clk) begin
        if (set_ins) r_set[r_count[AW-1:0]] <= r_ea[12:0];
        r_rd <= r_set[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_pid <= '0; r_usf <= 1'b0; r_fc <= '0; r_skip <= '0;
            r_phase <= PH_IDLE; r_sec <= '0; r_es <= '0; r_ea <= '0; r_ebc <= '0;
            r_known <= 1'b0; r_count <= '0; r_idx <= '0; r_rd_vld <= 1'b0;
            r_hit <= 1'b0; r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.step) begin
                r_pos <= n_pos; r_pid <= n_pid; r_usf <= n_usf; r_fc <= n_fc;
                r_skip <= n_skip; r_phase <= n_phase; r_sec <= n_sec;
                r_es <= n_es; r_ea <= n_ea; r_ebc <= n_ebc;
                if (hdr_scan || pat_scan) begin
                    r_idx    <= '0;
                    r_rd_vld <= 1'b0;
                    r_hit    <= 1'b0;
                end
            end else if (i_cmd.scan) begin
                if (r_rd_vld && r_rd == r_key) r_hit <= 1'b1;
                if (r_idx < r_count) begin
                    r_rd_vld <= 1'b1;
                    r_idx    <= r_idx + CW'(1);
                end else begin
                    r_rd_vld <= 1'b0;
                end
            end
            if (i_cmd.set_known) r_known <= r_hit;
            if (set_ins) r_count <= r_count + CW'(1);
            if (emit_now && i_cmd.step || i_cmd.emit_pat) r_out_valid <= 1'b1;
            else if (i_cmd.out_taken) r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && (hdr_scan || pat_scan)) r_key <= scan_key;
        if (i_cmd.step && emit_now) begin
            r_out <= emit_data;
        end else if (i_cmd.emit_pat) begin
            r_out.entry_kind     <= KIND_PAT;
            r_out.program_number <= r_ea[31:16];
            r_out.stream_pid     <= r_ea[12:0];
            r_out.stream_type    <= '0;
            r_out.table_full     <= !r_hit && (r_count >= SET_MAX);
        end
    end

    assign o_sts.hdr_scan  = hdr_scan;
    assign o_sts.pat_scan  = pat_scan;
    assign o_sts.scan_done = scan_done;
    assign o_sts.out_busy  = r_out_valid;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

endmodule
`default_nettype wire

/* tb/ts_pat_pmt_section_parser_unit_tb.sv */
// Testbench for ts_pat_pmt_section_parser_unit: random and directed TS packets
// carrying PAT/PMT sections, with a scoreboard that predicts every entry beat.
// Depends on tspp_pkg and the RTL top level.
`timescale 1ns / 1ps
module ts_pat_pmt_section_parser_unit_tb;
    import tspp_pkg::*;

    localparam int unsigned SET_DEPTH = 64;
    localparam int unsigned CYCLE_LIMIT = 3000000;

    // Predicts PAT/PMT entries from the accepted byte beats and checks results.
    class ts_table_scoreboard;
        t_out       entry_q[$];
        int         errors, n_results, n_pat, n_pmt, n_full;
        bit [7:0]   pos;
        bit [12:0]  pid;
        bit         pusi;
        bit [1:0]   fc;
        bit [7:0]   skip;
        t_phase     ph;
        bit [11:0]  sec_left, es_left;
        bit [39:0]  asm_bits;
        bit [2:0]   ecnt;
        bit [12:0]  pmt_set[$];

        function new();
            ph = PH_IDLE;
        endfunction

        function bit known(bit [12:0] p);
            foreach (pmt_set[i]) if (pmt_set[i] == p) return 1;
            return 0;
        endfunction

        function void open_payload();
            if (!pusi || (pid != 0 && !known(pid))) ph = PH_DONE;
            else ph = PH_PTR;
        endfunction

        function void take();
            if (sec_left > 0) sec_left--;
        endfunction

        function void note_byte(t_in b);
            bit [7:0]  d;
            bit        is_pat;
            int        need;
            t_out      r;
            d = b.data_byte;
            if (b.packet_start) begin
                pos = 0;
                ph = PH_HDR;
                return;
            end
            if (ph == PH_IDLE) return;
            pos++;
            if (pos >= PACKET_BYTES) begin
                pos = 8'(PACKET_BYTES);
                ph = PH_IDLE;
                return;
            end
            is_pat = (pid == 0);
            case (ph)
                PH_HDR: begin
                    if (pos == 1) begin
                        pusi = d[6];
                        pid = {d[4:0], 8'h00};
                    end else if (pos == 2) begin
                        pid[7:0] = d;
                    end else begin
                        fc = d[5:4];
                        if (fc == FC_BOTH) ph = PH_AFLEN;
                        else if (fc == FC_PAYLOAD) open_payload();
                        else ph = PH_DONE;
                    end
                end
                PH_AFLEN: begin
                    skip = d;
                    if (d == 0) open_payload(); else ph = PH_AFSKIP;
                end
                PH_AFSKIP: begin
                    if (skip > 0) skip--;
                    if (skip == 0) open_payload();
                end
                PH_PTR: begin
                    skip = d;
                    ph = (d == 0) ? PH_TBLHDR : PH_PTRSKIP;
                end
                PH_PTRSKIP: begin
                    if (skip > 0) skip--;
                    if (skip == 0) ph = PH_TBLHDR;
                end
                PH_TBLHDR: begin
                    if (skip == 1) asm_bits = {36'd0, d[3:0]};
                    else if (skip == 2) sec_left = {asm_bits[3:0], d};
                    else if (skip >= 3) begin
                        take();
                        if (skip == 10) asm_bits = {36'd0, d[3:0]};
                        if (skip == 11) es_left = {asm_bits[3:0], d};
                    end
                    skip++;
                    if (is_pat && skip == 8) begin
                        ph = PH_ENTRY;
                        ecnt = 0;
                    end else if (!is_pat && skip == 12) begin
                        ph = (es_left == 0) ? PH_ENTRY : PH_PINFO;
                        ecnt = 0;
                    end
                end
                PH_PINFO, PH_ESSKIP: begin
                    if (sec_left <= 4) begin
                        ph = PH_DONE;
                        return;
                    end
                    take();
                    if (es_left > 0) es_left--;
                    if (es_left == 0) begin
                        ph = PH_ENTRY;
                        ecnt = 0;
                    end
                end
                PH_ENTRY: begin
                    need = is_pat ? 4 : 5;
                    if (ecnt == 0 && int'(sec_left) < need + 4) begin
                        ph = PH_DONE;
                        return;
                    end
                    take();
                    asm_bits = {asm_bits[31:0], d};
                    ecnt++;
                    if (ecnt < need) return;
                    ecnt = 0;
                    r = '0;
                    if (is_pat) begin
                        r.entry_kind = KIND_PAT;
                        r.program_number = asm_bits[31:16];
                        r.stream_pid = asm_bits[12:0];
                        if (r.program_number != 0 && r.stream_pid != 0
                                && !known(r.stream_pid)) begin
                            if (pmt_set.size() < SET_DEPTH) pmt_set.push_back(r.stream_pid);
                            else r.table_full = 1'b1;
                        end
                    end else begin
                        r.entry_kind = KIND_PMT;
                        r.stream_pid = asm_bits[28:16];
                        r.stream_type = asm_bits[39:32];
                        es_left = asm_bits[11:0];
                        if (es_left != 0) ph = PH_ESSKIP;
                    end
                    entry_q.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_entry(t_out got);
            t_out want;
            if (entry_q.size() == 0) begin
                $error("unexpected result beat %h", got);
                errors++;
                return;
            end
            want = entry_q.pop_front();
            n_results++;
            if (got.entry_kind == KIND_PAT) n_pat++; else n_pmt++;
            if (got.table_full) n_full++;
            if (got.entry_kind != want.entry_kind) begin
                $error("entry_kind exp %0h got %0h", want.entry_kind, got.entry_kind);
                errors++;
            end
            if (got.program_number != want.program_number) begin
                $error("program_number exp %0h got %0h", want.program_number,
                       got.program_number);
                errors++;
            end
            if (got.stream_pid != want.stream_pid) begin
                $error("stream_pid exp %0h got %0h", want.stream_pid, got.stream_pid);
                errors++;
            end
            if (got.stream_type != want.stream_type) begin
                $error("stream_type exp %0h got %0h", want.stream_type, got.stream_type);
                errors++;
            end
            if (got.table_full != want.table_full) begin
                $error("table_full exp %0h got %0h", want.table_full, got.table_full);
                errors++;
            end
        endfunction
    endclass

    logic  i_clk, i_rst_n;
    logic  in_valid, out_stall;
    t_in   in_beat;
    logic  o_in_stall, o_out_valid;
    t_out  o_out;

    ts_table_scoreboard sb;
    int    n_sent;
    int    cycles;
    bit    calm;
    int    stall_left, run_left;
    bit [7:0] pkt[$];

    ts_pat_pmt_section_parser_unit #(.PMT_SET_DEPTH(SET_DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(o_in_stall), .i_in(in_beat),
        .o_out_valid(o_out_valid), .i_out_stall(out_stall), .o_out(o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[ts_pat_pmt_section_parser_unit] ERROR");
            $finish;
        end
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) sb.note_byte(in_beat);
            if (o_out_valid && !out_stall) sb.check_entry(o_out);
        end
    end

    // Receiver: alternate runs of acceptance and stalls, mostly short ones.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end else if (run_left > 0) begin
            run_left <= run_left - 1;
            out_stall <= 1'b0;
        end else begin
            out_stall <= 1'b0;
            run_left <= $urandom_range(1, 40);
            if ($urandom_range(0, 9) == 0) stall_left <= $urandom_range(10, 40);
            else stall_left <= $urandom_range(0, 3);
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(bit [7:0] d, bit start);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat <= '{data_byte: d, packet_start: start};
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        n_sent++;
    endtask

    function automatic bit [7:0] rnd8();
        return 8'($urandom);
    endfunction

    function automatic void put_header(bit [12:0] p, bit start_unit, bit [1:0] afc);
        int n;
        pkt.delete();
        pkt.push_back(($urandom_range(0, 9) == 0) ? rnd8() : 8'h47);
        pkt.push_back({1'($urandom), start_unit, 1'($urandom), p[12:8]});
        pkt.push_back(p[7:0]);
        pkt.push_back({2'($urandom), afc, 4'($urandom)});
        if (afc == FC_BOTH) begin
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            pkt.push_back(8'(n));
            repeat (n) pkt.push_back(rnd8());
        end
    endfunction

    // Pointer field, then the section; length field is usually consistent.
    function automatic void put_section(bit [7:0] sec[$], int body_len);
        int ptr, len;
        ptr = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        pkt.push_back(8'(ptr));
        repeat (ptr) pkt.push_back(rnd8());
        len = body_len;
        case ($urandom_range(0, 19))
            0: len = $urandom_range(0, 15);
            1: len = $urandom_range(0, 4095);
            2: len = body_len - $urandom_range(1, 8);
            default: ;
        endcase
        if (len < 0) len = 0;
        pkt.push_back(8'h00 | 8'($urandom_range(0, 2)));
        pkt.push_back({4'($urandom), 4'(len >> 8)});
        pkt.push_back(8'(len));
        foreach (sec[i]) pkt.push_back(sec[i]);
    endfunction

    function automatic bit [12:0] pick_pid();
        if (sb.pmt_set.size() > 0 && $urandom_range(0, 5) == 0)
            return sb.pmt_set[$urandom_range(0, sb.pmt_set.size() - 1)];
        if ($urandom_range(0, 9) == 0) return 13'd0;
        return 13'($urandom_range(1, 8191));
    endfunction

    function automatic void build_pat();
        bit [7:0]  sec[$];
        int        n;
        bit [15:0] prog;
        bit [12:0] p;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : $urandom_range(25, 42);
        repeat (5) sec.push_back(rnd8());
        repeat (n) begin
            prog = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
            p = pick_pid();
            sec.push_back(prog[15:8]);
            sec.push_back(prog[7:0]);
            sec.push_back({3'($urandom), p[12:8]});
            sec.push_back(p[7:0]);
        end
        repeat (4) sec.push_back(rnd8());
        put_header(13'd0, 1'b1, ($urandom_range(0, 4) == 0) ? FC_BOTH : FC_PAYLOAD);
        put_section(sec, 5 + 4 * n + 4);
    endfunction

    function automatic void build_pmt(bit [12:0] p);
        bit [7:0] sec[$];
        int n, pinfo, es;
        bit [12:0] ep;
        repeat (7) sec.push_back(rnd8());
        pinfo = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
        sec.push_back({4'($urandom), 4'(pinfo >> 8)});
        sec.push_back(8'(pinfo));
        repeat (pinfo) sec.push_back(rnd8());
        n = $urandom_range(0, 14);
        repeat (n) begin
            es = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
            ep = 13'($urandom);
            sec.push_back(rnd8());
            sec.push_back({3'($urandom), ep[12:8]});
            sec.push_back(ep[7:0]);
            sec.push_back({4'($urandom), 4'(es >> 8)});
            sec.push_back(8'(es));
            repeat (es) sec.push_back(rnd8());
        end
        repeat (4) sec.push_back(rnd8());
        put_header(p, 1'b1, ($urandom_range(0, 4) == 0) ? FC_BOTH : FC_PAYLOAD);
        put_section(sec, sec.size());
    endfunction

    task automatic send_packet();
        int kind, total;
        kind = $urandom_range(0, 99);
        if (kind < 40 || (kind < 75 && sb.pmt_set.size() == 0)) build_pat();
        else if (kind < 75) build_pmt(sb.pmt_set[$urandom_range(0, sb.pmt_set.size() - 1)]);
        else begin
            put_header(($urandom_range(0, 2) == 0) ? 13'd0 : 13'($urandom),
                       1'($urandom), 2'($urandom));
            repeat ($urandom_range(0, 30)) pkt.push_back(rnd8());
        end
        while (pkt.size() < PACKET_BYTES)
            pkt.push_back(($urandom_range(0, 3) == 0) ? rnd8() : 8'hFF);
        total = PACKET_BYTES;
        case ($urandom_range(0, 19))
            0: total = $urandom_range(4, PACKET_BYTES - 1);
            1: total = PACKET_BYTES + $urandom_range(1, 5);
            default: ;
        endcase
        calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < total; i++)
            send_beat((i < PACKET_BYTES) ? pkt[i] : rnd8(), i == 0);
    endtask

    initial begin
        int pkts;
        sb = new();
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_beat = '0;
        out_stall = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: stray bytes before any sync, a no-payload PAT header,
        // a continuation without unit start, then all-ones and all-zeros bytes.
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h47, 1'b1);
        send_beat(8'h40, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h20, 1'b0);
        send_beat(8'hAA, 1'b0);
        send_beat(8'h47, 1'b1);
        send_beat(8'h1F, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h10, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h47, 1'b1);
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b0);

        pkts = 0;
        while (pkts < 40 && n_sent + PACKET_BYTES / 2 < 1050) begin
            send_packet();
            pkts++;
            if (pkts == 2) begin
                in_valid <= 1'b0;
                while (sb.entry_q.size() != 0) @(negedge i_clk);
            end
        end
        in_valid <= 1'b0;
        while (sb.entry_q.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);

        $display("Sent %0d bytes in %0d packets; checked %0d entries (%0d PAT, %0d PMT).",
                 n_sent, pkts, sb.n_results, sb.n_pat, sb.n_pmt);
        $display("PMT PID set held %0d PIDs; %0d entries flagged the set as full.",
                 sb.pmt_set.size(), sb.n_full);
        if (sb.errors == 0 && sb.entry_q.size() == 0)
            $display("[ts_pat_pmt_section_parser_unit] OK");
        else
            $display("[ts_pat_pmt_section_parser_unit] ERROR");
        $finish;
    end
endmodule
